/* rtl/ulam_distance_threshold_macros.svh */
// Assertion macros used by the checker of the Ulam distance block.
`ifndef ULAM_DISTANCE_THRESHOLD_MACROS_SVH
`define ULAM_DISTANCE_THRESHOLD_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define UDT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("udt check failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define UDT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("udt check failed");

`endif

/* rtl/udt_pkg.sv */
// Package: sizes, register codes and item types of the Ulam distance block.
`timescale 1ns / 1ps
package udt_pkg;

    localparam int MAX_LEN = 16;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int ELEM_W  = 4;
    localparam int CFG_W   = 5;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    typedef enum logic {
        REG_SEQ_LENGTH   = 1'b0,
        REG_MIN_DISTANCE = 1'b1
    } udt_reg_t;

    typedef enum logic {
        ACT_LOAD   = 1'b0,
        ACT_STREAM = 1'b1
    } udt_action_t;

    typedef struct packed {
        logic              action;
        logic [ELEM_W-1:0] index;
        logic [ELEM_W-1:0] value;
        logic              last;
    } udt_in_t;

    typedef struct packed {
        logic [CFG_W-1:0] distance;
        logic             passed;
    } udt_out_t;

    typedef struct packed {
        logic              en;
        logic [ELEM_W-1:0] x;
    } udt_cell_ctrl_t;

endpackage

/* rtl/udt_cell.sv */
// One tail cell: holds a tail value, compares it and takes the new value.
`timescale 1ns / 1ps
module udt_cell (
    input  logic                    aclk,
    input  udt_pkg::udt_cell_ctrl_t ctrl,
    input  logic                    valid,
    input  logic                    prev_lt,
    output logic                    lt,
    output logic                    append
);
    import udt_pkg::*;

    logic [ELEM_W-1:0] tail_reg;
    logic [ELEM_W-1:0] tail_next;
    logic              replace;

    // Tails are sorted, so lt is a prefix; the first cell not below x is replaced.
    assign lt      = valid && (tail_reg < ctrl.x);
    assign replace = valid && !lt && prev_lt;
    assign append  = !valid && prev_lt;

    assign tail_next = (ctrl.en && (replace || append)) ? ctrl.x : tail_reg;

    always_ff @(posedge aclk) begin
        tail_reg <= tail_next;
    end

endmodule

/* rtl/udt_tail_chain.sv */
// Row of tail cells with the occupancy decode and the append flag.
`timescale 1ns / 1ps
module udt_tail_chain (
    input  logic                    aclk,
    input  udt_pkg::udt_cell_ctrl_t ctrl,
    input  logic [udt_pkg::LEN_W-1:0] len,
    output logic                    append_any
);
    import udt_pkg::*;

    logic [MAX_LEN-1:0] lt;
    logic [MAX_LEN-1:0] append;

    for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
        logic valid;
        logic prev_lt;

        assign valid = (len > LEN_W'(i));
        if (i == 0) begin : g_head
            assign prev_lt = 1'b1;
        end else begin : g_body
            assign prev_lt = lt[i-1];
        end

        udt_cell u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .valid   (valid),
            .prev_lt (prev_lt),
            .lt      (lt[i]),
            .append  (append[i])
        );
    end

    assign append_any = |append;

endmodule

/* rtl/ulam_distance_threshold.sv */
// Top level of the Ulam distance threshold block.
//
// Usage:
//   Input channel s_valid/s_ready/s_data carries items. A load item
//   (action 0) writes inverse_table[index] = value. A stream item
//   (action 1) maps value through the table and updates a row of
//   patience-sorting tail cells; the stream item with last set ends the
//   run and produces one result item on m_valid/m_ready/m_data.
//   Result: distance = seq_length - LIS length and passed = 1, or
//   distance 0 and passed 0 when the LIS grew past seq_length -
//   min_distance (early fail; further elements of that run are dropped).
//   The result item is registered and shown in the cycle after the last element
//   is taken. Throughput: one item per cycle while s_ready is high; all tail
//   cells compare against the mapped value at once and update in the same cycle.
//   The output register holds a result while the receiver stalls;
//   s_ready stays high as long as that register is empty or is being
//   emptied, so a stalled receiver stops input only once a result waits.
//   Reset (aresetn low, synchronous) clears the run state, the output
//   valid and sets seq_length 16, min_distance 0. The inverse table is
//   not cleared and must be loaded before use.
//   APB: seq_length at 0x0, min_distance at 0x4; write only while idle.
`timescale 1ns / 1ps
module ulam_distance_threshold (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [udt_pkg::APB_AW-1:0]    paddr,
    input  logic [udt_pkg::APB_DW-1:0]    pwdata,
    output logic [udt_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    // input items
    input  logic                          s_valid,
    output logic                          s_ready,
    input  udt_pkg::udt_in_t              s_data,
    // result items
    output logic                          m_valid,
    input  logic                          m_ready,
    output udt_pkg::udt_out_t             m_data
);
    import udt_pkg::*;

    localparam int SUM_W = ((LEN_W > CFG_W) ? LEN_W : CFG_W) + 1;

    // configuration registers
    logic [CFG_W-1:0]  seq_length_reg,   seq_length_next;
    logic [CFG_W-1:0]  min_distance_reg, min_distance_next;
    udt_reg_t          reg_sel;
    logic              cfg_write;

    // inverse table, loaded by items
    logic [ELEM_W-1:0] inv_table_reg [MAX_LEN];

    // run state
    logic [LEN_W-1:0]  len_reg,  len_next;
    logic              fail_reg, fail_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    udt_out_t          m_data_reg,  m_data_next;

    logic              s_fire;
    logic              take;
    logic              take_last;
    logic              append_any;
    logic              append_fire;
    logic [LEN_W-1:0]  grown_len;
    logic              fail_now;
    logic [SUM_W-1:0]  need_sum;
    logic [SUM_W-1:0]  dist_full;
    udt_cell_ctrl_t    cell_ctrl;

    // ---------------- APB ----------------
    assign pready    = 1'b1;
    assign reg_sel   = udt_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        seq_length_next   = seq_length_reg;
        min_distance_next = min_distance_reg;
        prdata            = '0;
        unique case (reg_sel)
            REG_SEQ_LENGTH: begin
                prdata = {{(APB_DW-CFG_W){1'b0}}, seq_length_reg};
                if (cfg_write) seq_length_next = pwdata[CFG_W-1:0];
            end
            REG_MIN_DISTANCE: begin
                prdata = {{(APB_DW-CFG_W){1'b0}}, min_distance_reg};
                if (cfg_write) min_distance_next = pwdata[CFG_W-1:0];
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // ---------------- item handshake ----------------
    // Take a new item whenever the output register is free or drains now.
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign take      = s_fire && (s_data.action == ACT_STREAM);
    assign take_last = take && s_data.last;

    // Hold the table; load items write one entry.
    always_ff @(posedge aclk) begin
        if (s_fire && (s_data.action == ACT_LOAD)) begin
            inv_table_reg[s_data.index] <= s_data.value;
        end
    end

    // Drop elements once the run has failed.
    assign cell_ctrl.en = take && !fail_reg;
    assign cell_ctrl.x  = inv_table_reg[s_data.value];

    udt_tail_chain u_chain (
        .aclk       (aclk),
        .ctrl       (cell_ctrl),
        .len        (len_reg),
        .append_any (append_any)
    );

    // ---------------- run bookkeeping ----------------
    assign append_fire = cell_ctrl.en && append_any;
    assign grown_len   = len_reg + LEN_W'(append_fire);

    // Fail when grown length exceeds seq_length - min_distance.
    assign need_sum = SUM_W'(grown_len) + SUM_W'(min_distance_reg);
    assign fail_now = fail_reg || (append_fire && (need_sum > SUM_W'(seq_length_reg)));

    // Saturate distance at zero when the LIS outgrows seq_length.
    assign dist_full = (SUM_W'(grown_len) < SUM_W'(seq_length_reg))
                     ? (SUM_W'(seq_length_reg) - SUM_W'(grown_len)) : '0;

    always_comb begin
        len_next     = grown_len;
        fail_next    = fail_now;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (take_last) begin
            // Report, then clear the run.
            len_next             = '0;
            fail_next            = 1'b0;
            m_valid_next         = 1'b1;
            m_data_next.passed   = !fail_now;
            m_data_next.distance = fail_now ? '0 : dist_full[CFG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_length_reg   <= CFG_W'(MAX_LEN);
            min_distance_reg <= '0;
            len_reg          <= '0;
            fail_reg         <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            seq_length_reg   <= seq_length_next;
            min_distance_reg <= min_distance_next;
            len_reg          <= len_next;
            fail_reg         <= fail_next;
            m_valid_reg      <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* rtl/udt_checker.sv */
// Port-level checker for the Ulam distance block and its bind.
`timescale 1ns / 1ps
`include "ulam_distance_threshold_macros.svh"
module udt_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input udt_pkg::udt_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input udt_pkg::udt_out_t m_data
);
    import udt_pkg::*;

    `UDT_ASSERT_NEXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_data))
    `UDT_ASSERT_NOW(a_fail_zero, m_valid && !m_data.passed, m_data.distance == '0)
    `UDT_ASSERT_NOW(a_ready_when_empty, !m_valid, s_ready)
    `UDT_ASSERT_NOW(a_result_from_last, $rose(m_valid),
        $past(s_valid && s_ready && (s_data.action == ACT_STREAM) && s_data.last))

endmodule

bind ulam_distance_threshold udt_checker u_udt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* tb/sv/ulam_distance_threshold_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the Ulam distance threshold block with its own LIS predictor.
module ulam_distance_threshold_tb;
    import udt_pkg::*;

    localparam int CLK_HALF_NS      = 5;
    localparam int RESET_CYCLES     = 4;
    // The result is registered and shows in the cycle after the last element; the pause adds margin.
    localparam int RESULT_LATENCY   = 1;
    localparam int DRAIN_CYCLES     = RESULT_LATENCY + 8;
    localparam int RANDOM_ITEMS     = 720;
    localparam int LONG_HOLD_CYCLES = 300;
    // Watchdog time for the whole simulation, well above the slowest run.
    localparam int TIMEOUT_NS       = 2_000_000;

    typedef enum int {
        RX_STEADY,
        RX_COIN,
        RX_ONE_IN_FOUR,
        RX_LONG_GAPS
    } rx_mode_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    udt_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    udt_out_t              m_data;

    // Predictor state: inverse table, patience tails, run length and fail flag.
    logic [ELEM_W-1:0]     inv_lut [MAX_LEN];
    logic [ELEM_W-1:0]     tails   [MAX_LEN];
    int                    lis_len    = 0;
    bit                    run_failed = 1'b0;
    int                    cfg_len    = 16;
    int                    cfg_min    = 0;
    // Reference order of the loaded table: ref_perm[position] = element.
    int                    ref_perm [MAX_LEN];

    udt_out_t              dist_expect_q [$];
    udt_out_t              want;
    int                    err_count  = 0;
    int                    items_sent = 0;

    // Sender and receiver idling controls.
    bit                    tx_gaps_on   = 1'b0;
    bit                    rx_stalls_on = 1'b0;
    bit                    hold_request = 1'b0;
    int                    burst_left   = 0;
    int                    rx_hold_left = 0;
    int                    rx_mode_left = 0;
    int                    rx_phase     = 0;
    rx_mode_t              rx_mode      = RX_STEADY;

    ulam_distance_threshold u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF_NS aclk = ~aclk;
    end

    // Advance the predictor by one accepted item; flag a result on the last element.
    function automatic void ulam_predict(input udt_in_t item, output bit produces,
                                         output udt_out_t res);
        logic [ELEM_W-1:0] x;
        int pos;
        produces = 1'b0;
        res = '0;
        if (item.action == ACT_LOAD) begin
            inv_lut[item.index] = item.value;
            return;
        end
        // Drop elements once the run has failed early.
        if (!run_failed) begin
            x = inv_lut[item.value];
            pos = 0;
            while (pos < lis_len && tails[pos] < x) pos++;
            if (pos < lis_len) begin
                tails[pos] = x;
            end else if (lis_len < MAX_LEN) begin
                tails[lis_len] = x;
                lis_len++;
                if (lis_len > cfg_len - cfg_min) run_failed = 1'b1;
            end
        end
        if (!item.last) return;
        produces = 1'b1;
        if (!run_failed) begin
            res.distance = (lis_len < cfg_len) ? CFG_W'(cfg_len - lis_len) : '0;
            res.passed   = 1'b1;
        end
        lis_len = 0;
        run_failed = 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    // Offer one item, hold it until taken, then predict its result.
    task automatic send_item(input udt_in_t item);
        bit took;
        bit has_res;
        udt_out_t res;
        int gap;
        if (tx_gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        s_valid <= 1'b1;
        s_data  <= item;
        // Sample ready mid-cycle: it is settled and holds until the next edge.
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        ulam_predict(item, has_res, res);
        if (has_res) dist_expect_q = {dist_expect_q, res};
        items_sent++;
    endtask

    task automatic load_entry(input int idx, input int val, input bit last_mark);
        udt_in_t item;
        item.action = ACT_LOAD;
        item.index  = ELEM_W'(idx);
        item.value  = ELEM_W'(val);
        item.last   = last_mark;
        send_item(item);
    endtask

    task automatic stream_elem(input int val, input bit last_mark);
        udt_in_t item;
        item.action = ACT_STREAM;
        item.index  = ELEM_W'($urandom_range(0, MAX_LEN - 1));
        item.value  = ELEM_W'(val);
        item.last   = last_mark;
        send_item(item);
    endtask

    // Stream one candidate; now and then rewrite a table entry with its own value
    // in between, so loads land in the middle of a run without changing it.
    task automatic send_run(input int elems [$]);
        int k;
        for (int i = 0; i < elems.size(); i++) begin
            if ($urandom_range(0, 11) == 0) begin
                k = $urandom_range(0, MAX_LEN - 1);
                load_entry(k, int'(inv_lut[k]), 1'($urandom_range(0, 1)));
            end
            stream_elem(elems[i], i == elems.size() - 1);
        end
    endtask

    // Drop valid, wait for every expected result, then let the block settle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (dist_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Setup and access cycle; the register takes the value at the access edge.
    task automatic write_reg(input udt_reg_t which, input int val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= APB_DW'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (which == REG_SEQ_LENGTH) cfg_len = val & 31;
        else cfg_min = val & 31;
    endtask

    task automatic set_config(input int len, input int min_dist);
        wait_idle();
        write_reg(REG_SEQ_LENGTH, len);
        write_reg(REG_MIN_DISTANCE, min_dist);
    endtask

    function automatic void shuffle_symbols(output int sym [MAX_LEN]);
        int j;
        int t;
        for (int i = 0; i < MAX_LEN; i++) sym[i] = i;
        for (int i = MAX_LEN - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = sym[i];
            sym[i] = sym[j];
            sym[j] = t;
        end
    endfunction

    // Load the inverse of a fresh random reference permutation, in random index order.
    task automatic reload_table();
        shuffle_symbols(ref_perm);
        for (int p = 0; p < MAX_LEN; p++)
            load_entry(ref_perm[p], p, 1'($urandom_range(0, 1)));
    endtask

    // Identity table; the final load carries a last mark that must be ignored.
    task automatic test_table_load();
        for (int i = 0; i < MAX_LEN; i++) begin
            ref_perm[i] = i;
            load_entry(i, i, i == MAX_LEN - 1);
        end
    endtask

    // Default setting: single element, a full tail store, and a falling pair.
    task automatic test_edge_runs();
        int run_q [$];
        run_q = '{MAX_LEN - 1};
        send_run(run_q);
        run_q = {};
        for (int i = 0; i < MAX_LEN; i++) run_q = {run_q, i};
        send_run(run_q);
        run_q = '{MAX_LEN - 1, 0};
        send_run(run_q);
    endtask

    // Threshold at or above the length, and elements ignored after an early fail.
    task automatic test_threshold_cases();
        int run_q [$];
        set_config(1, 16);
        run_q = '{0};
        send_run(run_q);
        set_config(4, 2);
        run_q = '{0, 1, 2, 3, MAX_LEN - 1};
        send_run(run_q);
        set_config(16, 16);
        run_q = '{7};
        send_run(run_q);
        wait_idle();
    endtask

    // Hold the receiver off while short runs keep coming, so the input stalls.
    task automatic test_backpressure();
        tx_gaps_on = 1'b0;
        set_config(16, 0);
        hold_request = 1'b1;
        for (int k = 0; k < 30; k++)
            stream_elem($urandom_range(0, MAX_LEN - 1), k % 2 == 1);
        wait_idle();
    endtask

    // Phases of random runs, mostly well-formed candidates, under varied settings.
    task automatic test_random();
        int target;
        int phase;
        int kind;
        int n;
        int m;
        int a;
        int b;
        int t;
        int nruns;
        int sym [MAX_LEN];
        int run_q [$];
        target = items_sent + RANDOM_ITEMS;
        phase = 0;
        while (items_sent < target) begin
            // Visit the corner settings first, then pick at random.
            unique case (phase)
                0: set_config(1, 0);
                1: set_config(1, 16);
                2: set_config(16, 16);
                3: set_config(16, 0);
                default: set_config($urandom_range(1, 16),
                                    ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16)
                                                                : $urandom_range(0, 4));
            endcase
            tx_gaps_on   = $urandom_range(0, 3) != 0;
            rx_stalls_on = $urandom_range(0, 3) != 0;
            nruns = $urandom_range(6, 14);
            for (int r = 0; r < nruns; r++) begin
                kind = $urandom_range(0, 9);
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_LEN) : cfg_len;
                run_q = {};
                if (kind <= 3) begin
                    shuffle_symbols(sym);
                    for (int i = 0; i < n; i++) run_q = {run_q, sym[i]};
                end else if (kind <= 6 || kind == 8) begin
                    // Near the reference order: long subsequences, early fails.
                    for (int i = 0; i < n; i++) run_q = {run_q, ref_perm[i]};
                    repeat ($urandom_range(0, 3)) begin
                        a = $urandom_range(0, n - 1);
                        b = $urandom_range(0, n - 1);
                        t = run_q[a];
                        run_q[a] = run_q[b];
                        run_q[b] = t;
                    end
                    if (kind == 8) begin
                        // Break it: cut it short or pad with stray elements.
                        m = $urandom_range(1, n + 4);
                        while (run_q.size() > m) void'(run_q.pop_back());
                        while (run_q.size() < m)
                            run_q = {run_q, int'($urandom_range(0, MAX_LEN - 1))};
                    end
                end else if (kind == 7) begin
                    m = $urandom_range(1, 20);
                    for (int i = 0; i < m; i++)
                        run_q = {run_q, int'($urandom_range(0, MAX_LEN - 1))};
                end
                if (kind == 9) reload_table();
                else send_run(run_q);
            end
            phase++;
        end
        wait_idle();
    endtask

    // Receiver: long hold when asked; else always ready or a stall pattern that changes at times.
    always @(posedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            rx_hold_left = LONG_HOLD_CYCLES;
        end
        if (rx_mode_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 80);
        end
        rx_mode_left--;
        rx_phase++;
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else if (!rx_stalls_on) begin
            m_ready <= 1'b1;
        end else begin
            unique case (rx_mode)
                RX_STEADY:      m_ready <= 1'b1;
                RX_COIN:        m_ready <= 1'($urandom_range(0, 1));
                RX_ONE_IN_FOUR: m_ready <= (rx_phase % 4) == 0;
                default:        m_ready <= (rx_phase % 16) < 10;
            endcase
        end
    end

    // Check each result taken at the coming edge against the oldest expectation.
    always @(negedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (dist_expect_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: distance %0d passed %0b",
                                          m_data.distance, m_data.passed));
            end else begin
                want = dist_expect_q.pop_front();
                if (m_data.distance !== want.distance)
                    report_mismatch($sformatf("distance %0d, expected %0d",
                                              m_data.distance, want.distance));
                if (m_data.passed !== want.passed)
                    report_mismatch($sformatf("passed %0b, expected %0b",
                                              m_data.passed, want.passed));
            end
        end
    end

    initial begin
        aresetn <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_table_load();
        test_edge_runs();
        test_threshold_cases();
        test_backpressure();
        test_random();
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("TIMEOUT at %0t ns", $time);
        $display("Some tests failed");
        $finish;
    end

endmodule

/* ulam_distance_threshold.f */
+incdir+rtl
rtl/udt_pkg.sv
rtl/udt_cell.sv
rtl/udt_tail_chain.sv
rtl/ulam_distance_threshold.sv
rtl/udt_checker.sv
tb/sv/ulam_distance_threshold_tb.sv
